@@ sv/first_fit_bin_packer_core_defines.svh @@
// Assertion macros for the first-fit bin packer.
// Depends on nothing; the asserting modules must have ports named clock and reset.
`ifndef FIRST_FIT_BIN_PACKER_CORE_DEFINES_SVH
`define FIRST_FIT_BIN_PACKER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FFBP_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);
`define FFBP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define FFBP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define FFBP_ASSERT_ALWAYS(lbl, expr, msg)
`define FFBP_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define FFBP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/ffbp_pkg.sv @@
// Shared types and constants of the first-fit bin packer.
// Depends on nothing; used by ffbp_ctrl and first_fit_bin_packer_core.
package ffbp_pkg;

   localparam int LEN_W     = 16;
   localparam int TYPE_W    = 4;
   localparam int BIN_IDX_W = 8;
   localparam int USED_W    = 9;
   localparam int COUNT_W   = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;
   localparam logic [LEN_W-1:0]   STOCK_RESET = 16'hFFFF;

   typedef struct packed {
      logic [LEN_W-1:0]  piece_length;
      logic [TYPE_W-1:0] type_index;
      logic              restart;
   } req_type;

   typedef struct packed {
      logic [BIN_IDX_W-1:0] bin_index;
      logic                 opened_new;
      logic [USED_W-1:0]    bins_used;
      logic [COUNT_W-1:0]   count_in_bin;
      logic                 failed;
   } rsp_type;

endpackage

@@ sv/ffbp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module ffbp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ffbp_ctrl.sv @@
// Scan and update sequencer of the first-fit bin packer, with its two memories.
// Depends on ffbp_pkg, ffbp_ram and first_fit_bin_packer_core_defines.svh.
`include "first_fit_bin_packer_core_defines.svh"
module ffbp_ctrl #(
   parameter int MAX_BINS  = 256,
   parameter int MAX_TYPES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ffbp_pkg::req_type             req_data,
   input  logic [ffbp_pkg::LEN_W-1:0]    stock_length,
   output logic                          res_valid,
   input  logic                          res_ready,
   output ffbp_pkg::rsp_type             res_data
);

   localparam int BIN_W   = $clog2(MAX_BINS);
   localparam int CNT_W   = $clog2(MAX_BINS + 1);
   localparam int CELLS   = MAX_BINS * MAX_TYPES;
   localparam int CADDR_W = $clog2(CELLS);
   localparam int LEN_W   = ffbp_pkg::LEN_W;
   localparam int SPACE_W = LEN_W + MAX_TYPES;

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      CNT_RD,
      CNT_WR,
      DONE
   } state_type;

   state_type                     state_ff;
   logic [LEN_W-1:0]              len_ff;
   logic [ffbp_pkg::TYPE_W-1:0]   type_ff;
   logic [CNT_W-1:0]              open_ff;
   logic [CNT_W-1:0]              issue_ff;
   logic [CNT_W-1:0]              chk_ff;
   logic                          chk_vld_ff;
   logic [BIN_W-1:0]              bin_ff;
   logic                          new_ff;
   logic [LEN_W-1:0]              space_ff;
   logic [MAX_TYPES-1:0]          mask_ff;
   ffbp_pkg::rsp_type             res_ff;

   logic [CNT_W-1:0]              open_eff;
   logic [CNT_W-1:0]              open_inc;
   logic                          type_ok;
   logic                          fits;
   logic                          last_chk;
   logic                          table_full;
   logic [MAX_TYPES-1:0]          type_bit;
   logic                          hit;
   logic [31:0]                   caddr_wide;
   logic [CADDR_W-1:0]            cnt_addr;
   logic [ffbp_pkg::COUNT_W-1:0]  cnt_rd_data;
   logic [ffbp_pkg::COUNT_W-1:0]  old_cnt;
   logic [ffbp_pkg::COUNT_W-1:0]  new_cnt;
   logic                          cnt_rd_en;
   logic                          cnt_wr_en;
   logic                          sp_rd_en;
   logic                          sp_wr_en;
   logic [SPACE_W-1:0]            sp_rd_data;
   logic [SPACE_W-1:0]            sp_wr_data;
   logic [LEN_W-1:0]              rd_space;
   logic [MAX_TYPES-1:0]          rd_mask;
   logic [BIN_W+ffbp_pkg::BIN_IDX_W-1:0] bin_wide;
   logic [CNT_W+ffbp_pkg::USED_W-1:0]    used_wide;

   function automatic ffbp_pkg::rsp_type fail_rsp(input logic [CNT_W-1:0] used);
      logic [CNT_W+ffbp_pkg::USED_W-1:0] wide;
      ffbp_pkg::rsp_type                 r;
      wide           = {{ffbp_pkg::USED_W{1'b0}}, used};
      r.bin_index    = '0;
      r.opened_new   = 1'b0;
      r.bins_used    = wide[ffbp_pkg::USED_W-1:0];
      r.count_in_bin = '0;
      r.failed       = 1'b1;
      return r;
   endfunction

   assign open_eff   = req_data.restart ? '0 : open_ff;
   assign open_inc   = CNT_W'(open_ff + CNT_W'(1));
   assign type_ok    = 32'(req_data.type_index) < MAX_TYPES;
   assign fits       = req_data.piece_length <= stock_length;
   assign last_chk   = CNT_W'(chk_ff + CNT_W'(1)) == open_ff;
   assign table_full = 32'(open_ff) == MAX_BINS;
   assign type_bit   = MAX_TYPES'(1) << type_ff;

   // Each bin keeps a mask of the types it holds, so count cells of a bin opened
   // since the last restart read as zero until that type is first written there.
   assign rd_space   = sp_rd_data[LEN_W-1:0];
   assign rd_mask    = sp_rd_data[SPACE_W-1:LEN_W];
   assign hit        = |(mask_ff & type_bit);

   assign caddr_wide = 32'(bin_ff) * 32'(MAX_TYPES) + 32'(type_ff);
   assign cnt_addr   = caddr_wide[CADDR_W-1:0];
   assign old_cnt    = hit ? cnt_rd_data : '0;
   assign new_cnt    = (old_cnt == ffbp_pkg::COUNT_MAX) ? old_cnt
                                                        : old_cnt + 16'd1;

   assign sp_rd_en   = (state_ff == SCAN) && (issue_ff < open_ff);
   assign sp_wr_en   = (state_ff == CNT_WR);
   assign sp_wr_data = {mask_ff | type_bit, space_ff};
   assign cnt_rd_en  = (state_ff == CNT_RD);
   assign cnt_wr_en  = (state_ff == CNT_WR);

   assign bin_wide   = {{ffbp_pkg::BIN_IDX_W{1'b0}}, bin_ff};
   assign used_wide  = {{ffbp_pkg::USED_W{1'b0}}, (new_ff ? open_inc : open_ff)};

   assign req_ready  = (state_ff == IDLE);
   assign res_valid  = (state_ff == DONE);
   assign res_data   = res_ff;

   ffbp_ram #(
      .WIDTH (SPACE_W),
      .DEPTH (MAX_BINS)
   ) u_space_ram (
      .clock   (clock),
      .wr_en   (sp_wr_en),
      .wr_addr (bin_ff),
      .wr_data (sp_wr_data),
      .rd_en   (sp_rd_en),
      .rd_addr (issue_ff[BIN_W-1:0]),
      .rd_data (sp_rd_data)
   );

   ffbp_ram #(
      .WIDTH (ffbp_pkg::COUNT_W),
      .DEPTH (CELLS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_addr),
      .wr_data (new_cnt),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_addr),
      .rd_data (cnt_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= IDLE;
         open_ff    <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  len_ff     <= req_data.piece_length;
                  type_ff    <= req_data.type_index;
                  open_ff    <= open_eff;
                  issue_ff   <= '0;
                  chk_vld_ff <= 1'b0;
                  if (!type_ok || !fits) begin
                     res_ff   <= fail_rsp(open_eff);
                     state_ff <= DONE;
                  end else if (open_eff == '0) begin
                     bin_ff   <= '0;
                     new_ff   <= 1'b1;
                     space_ff <= stock_length - req_data.piece_length;
                     mask_ff  <= '0;
                     state_ff <= CNT_RD;
                  end else begin
                     new_ff   <= 1'b0;
                     state_ff <= SCAN;
                  end
               end
            end
            SCAN: begin
               // Reads are issued one per cycle; the compare runs one entry behind.
               if (sp_rd_en) begin
                  issue_ff <= CNT_W'(issue_ff + CNT_W'(1));
               end
               chk_ff     <= issue_ff;
               chk_vld_ff <= sp_rd_en;
               if (chk_vld_ff) begin
                  if (rd_space >= len_ff) begin
                     bin_ff   <= chk_ff[BIN_W-1:0];
                     space_ff <= rd_space - len_ff;
                     mask_ff  <= rd_mask;
                     state_ff <= CNT_RD;
                  end else if (last_chk) begin
                     if (table_full) begin
                        res_ff   <= fail_rsp(open_ff);
                        state_ff <= DONE;
                     end else begin
                        bin_ff   <= open_ff[BIN_W-1:0];
                        new_ff   <= 1'b1;
                        space_ff <= stock_length - len_ff;
                        mask_ff  <= '0;
                        state_ff <= CNT_RD;
                     end
                  end
               end
            end
            CNT_RD: begin
               state_ff <= CNT_WR;
            end
            CNT_WR: begin
               res_ff.bin_index    <= bin_wide[ffbp_pkg::BIN_IDX_W-1:0];
               res_ff.opened_new   <= new_ff;
               res_ff.bins_used    <= used_wide[ffbp_pkg::USED_W-1:0];
               res_ff.count_in_bin <= new_cnt;
               res_ff.failed       <= 1'b0;
               if (new_ff) begin
                  open_ff <= open_inc;
               end
               state_ff <= DONE;
            end
            DONE: begin
               if (res_ready) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   `FFBP_ASSERT_ALWAYS(a_open_bound, 32'(open_ff) <= MAX_BINS, "open bin count exceeds table")
   `FFBP_ASSERT_IMPLIES(a_chk_in_range, (state_ff == SCAN) && chk_vld_ff, chk_ff < open_ff, "scan checked a bin that is not open")
   `FFBP_ASSERT_IMPLIES(a_fail_clean, res_valid && res_data.failed, (res_data.count_in_bin == '0) && !res_data.opened_new, "failed result carries placement data")
   `FFBP_ASSERT_IMPLIES(a_count_nonzero, res_valid && !res_data.failed, res_data.count_in_bin != '0, "placed piece reports a zero count")
   `FFBP_ASSERT_NEXT(a_open_grows, (state_ff == CNT_WR) && new_ff, open_ff != $past(open_ff), "opening a bin did not advance the open count")

endmodule

@@ sv/first_fit_bin_packer_core.sv @@
// First-fit bin packer. One request at a time: the space-left memory is scanned from bin 0,
// one entry per cycle, until a bin with room is found; if none has room a new bin is opened
// (at once when no bin is open), or the request is refused when the table is full, and a
// rejected request skips the scan. The single read port of the space memory sets the scan
// rate. A restart takes effect at once with no clearing pass, since each bin carries a
// mask of the types it holds. The next request is taken while a finished response waits
// in the output register.
// Depends on ffbp_pkg and ffbp_ctrl.
module first_fit_bin_packer_core #(
   parameter int MAX_BINS  = 256,
   parameter int MAX_TYPES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  ffbp_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output ffbp_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [ffbp_pkg::LEN_W-1:0]  csr_wr_data
);

   logic [ffbp_pkg::LEN_W-1:0] stock_ff;
   logic                       rsp_valid_ff;
   ffbp_pkg::rsp_type          rsp_data_ff;
   logic                       res_valid;
   logic                       res_ready;
   ffbp_pkg::rsp_type          res_data;

   assign res_ready = !rsp_valid_ff || rsp_ready;

   ffbp_ctrl #(
      .MAX_BINS  (MAX_BINS),
      .MAX_TYPES (MAX_TYPES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .stock_length (stock_ff),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res_data     (res_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stock_ff     <= ffbp_pkg::STOCK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            stock_ff <= csr_wr_data;
         end
         if (res_valid && res_ready) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= res_data;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
